FILE: rtl/fupd_pkg.sv
package fupd_pkg;

   // results one word can cause: a bad escape flushes two bytes, then the end flushes one
   localparam int RES_MAX     = 3;
   localparam int RES_W       = $clog2(RES_MAX + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int PREFIX_LEN  = 7;

   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_HASH     = 8'h23;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       uri_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       path_last;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic [RES_W-1:0]          count;
      rsp_type [RES_MAX-1:0]     item;
   } res_group_type;

   // "file://"
   function automatic logic [7:0] scheme_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h66;
         3'd1:    ch = 8'h69;
         3'd2:    ch = 8'h6C;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h3A;
         3'd5:    ch = 8'h2F;
         3'd6:    ch = 8'h2F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0_0000;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

FILE: rtl/file_uri_percent_decoder.sv
// file:// URI to path decoder.
// req channel: one word per URI byte (in_byte, has_byte), uri_end on the last
//   word of a URI; a word with has_byte 0 and uri_end 1 closes a URI with no
//   byte, e.g. an empty one.
// rsp channel: path bytes in order (byte_valid 1). The last word of every URI
//   has path_last 1; if no byte is left to carry it, it is a word with
//   byte_valid 0, and then rejected tells whether prefix was missing or no slash came after a host.
// Timing: a req word is decoded in the cycle it is accepted and its results
//   land in a 4-entry result queue at that edge; the first rsp word is valid
//   the next cycle. One req word per cycle is sustained while rsp_ready is high
//   and each word makes at most one result; a word that makes 2 or 3 results
//   (bad escape, flush at end) sends them one rsp word at a time through the
//   one-word-per-cycle queue read port.
// req_ready is high while the queue has room for 3 results, so it depends
//   only on registered fill, never on rsp_ready in the same cycle.
// Stall: when rsp_ready is low results wait in the queue and req_ready drops
//   once fill passes 1; nothing is lost.
// Reset: synchronous; queue empties and decoding restarts at prefix match.
module file_uri_percent_decoder
   import fupd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic                                go;
   logic                                dec_at_start;
   res_group_type                       dec_group;
   logic                                q_has_room;
   logic [$clog2(QUEUE_DEPTH + 1)-1:0]  q_fill;

   // word accepted: decode it now, push its results this edge
   assign go        = req_valid && req_ready;
   assign req_ready = q_has_room;

   fupd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .req_word (req_word),
      .group    (dec_group),
      .at_start (dec_at_start)
   );

   fupd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .group     (dec_group),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .has_room  (q_has_room),
      .fill      (q_fill)
   );

`ifndef SYNTH
   // end of URI always returns decoder to its start state
   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      go && req_word.uri_end |=> dec_at_start)
      else $error("decoder not at start after end of URI");

   // pushed results always fit in the queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (int'(q_fill) + int'(dec_group.count)) <= QUEUE_DEPTH)
      else $error("result queue overflow");

   // a rejection only comes on an empty closing word
   a_reject_form : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.rejected |-> rsp_word.path_last && !rsp_word.byte_valid)
      else $error("rejected set on a non-final or byte-carrying word");
`endif

endmodule

FILE: rtl/fupd_decode.sv
module fupd_decode
   import fupd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  req_type       req_word,
   output res_group_type group,
   output logic          at_start
);

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_AFTER,
      PH_SKIP,
      PH_DECODE,
      PH_DONE,
      PH_REJECT
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] prefix_index_ff, prefix_index_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic [7:0]             c;
   logic [4:0]             c_hex;
   logic [4:0]             held_hex;
   logic                   c_stop;
   logic                   c_pct;
   logic                   flush_pct;
   logic                   flush_held;
   logic                   do_plain;
   logic                   rej;
   logic [RES_W-1:0]       n_v;
   rsp_type [RES_MAX-1:0]  res_item;

   assign c        = req_word.in_byte;
   assign c_hex    = hex_decode(c);
   assign held_hex = hex_decode(held_byte_ff);
   assign c_stop   = (c == CH_QUESTION) || (c == CH_HASH);
   assign c_pct    = (c == CH_PERCENT);

   always_comb begin
      phase_in        = phase_ff;
      prefix_index_in = prefix_index_ff;
      held_count_in   = held_count_ff;
      held_byte_in    = held_byte_ff;
      flush_pct       = 1'b0;
      flush_held      = 1'b0;
      do_plain        = 1'b0;
      rej             = 1'b0;
      n_v             = '0;
      res_item        = '0;

      if (go && req_word.has_byte) begin
         case (phase_ff)
            PH_PREFIX: begin
               if (prefix_index_ff != 3'(PREFIX_LEN) && c == scheme_char(prefix_index_ff)) begin
                  if (prefix_index_ff == 3'(PREFIX_LEN - 1)) begin
                     phase_in        = PH_AFTER;
                     prefix_index_in = '0;
                  end else begin
                     prefix_index_in = prefix_index_ff + 3'd1;
                  end
               end else begin
                  phase_in = PH_REJECT;
               end
            end
            PH_AFTER, PH_SKIP: begin
               if (c == CH_SLASH) begin
                  phase_in    = PH_DECODE;
                  res_item[n_v] = {c, 1'b1, 1'b0, 1'b0};
                  n_v         = n_v + RES_W'(1);
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_DECODE: begin
               case (held_count_ff)
                  2'd0: begin
                     do_plain = 1'b1;
                  end
                  2'd1: begin
                     if (c_hex[4]) begin
                        held_byte_in  = c;
                        held_count_in = 2'd2;
                     end else begin
                        flush_pct     = 1'b1;
                        do_plain      = 1'b1;
                        held_count_in = 2'd0;
                     end
                  end
                  default: begin
                     held_count_in = 2'd0;
                     if (c_hex[4]) begin
                        res_item[n_v] = {held_hex[3:0], c_hex[3:0], 1'b1, 1'b0, 1'b0};
                        n_v           = n_v + RES_W'(1);
                     end else begin
                        flush_pct  = 1'b1;
                        flush_held = 1'b1;
                        do_plain   = 1'b1;
                     end
                  end
               endcase
               if (flush_pct) begin
                  res_item[n_v] = {CH_PERCENT, 1'b1, 1'b0, 1'b0};
                  n_v           = n_v + RES_W'(1);
               end
               if (flush_held) begin
                  res_item[n_v] = {held_byte_ff, 1'b1, 1'b0, 1'b0};
                  n_v           = n_v + RES_W'(1);
               end
               if (do_plain) begin
                  if (c_stop) begin
                     phase_in = PH_DONE;
                  end else if (c_pct) begin
                     held_count_in = 2'd1;
                  end else begin
                     res_item[n_v] = {c, 1'b1, 1'b0, 1'b0};
                     n_v           = n_v + RES_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (go && req_word.uri_end) begin
         // pending escape goes out as written
         if (phase_in == PH_DECODE && held_count_in != 2'd0) begin
            res_item[n_v] = {CH_PERCENT, 1'b1, 1'b0, 1'b0};
            n_v           = n_v + RES_W'(1);
            if (held_count_in != 2'd1) begin
               res_item[n_v] = {held_byte_in, 1'b1, 1'b0, 1'b0};
               n_v           = n_v + RES_W'(1);
            end
         end
         rej = (phase_in == PH_PREFIX) || (phase_in == PH_SKIP) || (phase_in == PH_REJECT);
         if (n_v == '0) begin
            res_item[0] = {8'h00, 1'b0, 1'b1, rej};
            n_v         = RES_W'(1);
         end else begin
            res_item[n_v - RES_W'(1)].path_last = 1'b1;
         end
         phase_in        = PH_PREFIX;
         prefix_index_in = '0;
         held_count_in   = '0;
      end
   end

   assign group.count = n_v;
   assign group.item  = res_item;
   assign at_start    = (phase_ff == PH_PREFIX) && (prefix_index_ff == '0)
                        && (held_count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         prefix_index_ff <= '0;
         held_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         prefix_index_ff <= prefix_index_in;
         held_count_ff   <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

FILE: rtl/fupd_queue.sv
module fupd_queue
   import fupd_pkg::*;
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  res_group_type                        group,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output rsp_type                              rsp_word,
   output logic                                 has_room,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   fill
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                pop;

   assign pop       = (fill_ff != '0) && rsp_ready;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(group.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign fill_in   = fill_ff + FILL_W'(group.count) - FILL_W'(pop);

   assign rsp_valid = (fill_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign has_room  = (fill_ff <= FILL_W'(QUEUE_DEPTH - RES_MAX));
   assign fill      = fill_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < RES_MAX; k++) begin
         if (RES_W'(k) < group.count) begin
            entry_ff[wr_ptr_ff + PTR_W'(k)] <= group.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
